/* hdl/kvt_pkg.sv */
// kvt_pkg: shared types and constants for the key/value table.
// Holds transaction structs, command codes and per-cell control.
// No dependencies.
package kvt_pkg;

	localparam int DEPTH      = 64;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int POS_BITS   = 6;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);

	// command codes
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_UPDATE = 3'd1;
	localparam logic [2:0] CMD_UPSERT = 3'd2;
	localparam logic [2:0] CMD_ERASE  = 3'd3;
	localparam logic [2:0] CMD_LOOKUP = 3'd4;
	localparam logic [2:0] CMD_READ   = 3'd5;

	typedef struct packed {
		logic [2:0]            command;
		logic [KEY_BITS-1:0]   req_key;
		logic [VALUE_BITS-1:0] req_value;
		logic [POS_BITS-1:0]   position;
	} kvt_req_t;

	typedef struct packed {
		logic                  ok;
		logic [KEY_BITS-1:0]   found_key;
		logic [VALUE_BITS-1:0] found_value;
		logic [CNT_W-1:0]      entries;
		logic                  is_empty;
	} kvt_rsp_t;

	// write controls for one cell of the chain
	typedef struct packed {
		logic load_new;  // append the request pair here
		logic load_val;  // overwrite the stored value
		logic shift;     // take the pair held by the next cell
	} kvt_cell_ctl_t;

endpackage

/* hdl/key_value_table.sv */
// key_value_table: one request at a time; req_stall is high while it is applied.
// The accept edge registers the hit vector from the parallel key compare across
// the cell chain; the apply edge does the write/shift and loads the response
// register and response valid, held off while the response is stalled.
// Reset clears the entry count and handshake state; cell storage is not cleared.
// Depends on kvt_pkg and kvt_cell.
module key_value_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  kvt_pkg::kvt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output kvt_pkg::kvt_rsp_t rsp
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_APPLY = 1'b1;

	logic                              state_q;
	logic [kvt_pkg::CNT_W-1:0]         count_q;
	logic [kvt_pkg::DEPTH-1:0]         hit_q;
	logic [2:0]                        cmd_q;
	logic [kvt_pkg::KEY_BITS-1:0]      key_q;
	logic [kvt_pkg::VALUE_BITS-1:0]    value_q;
	logic                              rsp_valid_q;
	kvt_pkg::kvt_rsp_t                 rsp_q;

	logic [kvt_pkg::KEY_BITS-1:0]      cell_key   [kvt_pkg::DEPTH];
	logic [kvt_pkg::VALUE_BITS-1:0]    cell_value [kvt_pkg::DEPTH];
	logic [kvt_pkg::DEPTH-1:0]         key_eq;
	logic [kvt_pkg::DEPTH-1:0]         hit_d;
	logic [kvt_pkg::DEPTH-1:0]         after;
	kvt_pkg::kvt_cell_ctl_t            cell_ctl [kvt_pkg::DEPTH];

	logic                              req_acc;
	logic                              apply_go;
	logic                              key_cmd;
	logic                              present;
	logic                              ok;
	logic                              do_ins;
	logic                              do_upd;
	logic                              do_erase;
	logic                              rd_key;
	logic                              rd_val;
	logic [kvt_pkg::CNT_W-1:0]         count_d;
	logic [kvt_pkg::KEY_BITS-1:0]      or_key;
	logic [kvt_pkg::VALUE_BITS-1:0]    or_value;

	assign req_stall = (state_q == ST_APPLY);
	assign req_acc   = req_valid && !req_stall;
	assign apply_go  = (state_q == ST_APPLY) && (!rsp_valid_q || !rsp_stall);
	assign key_cmd   = (req.command == kvt_pkg::CMD_INSERT) ||
	                   (req.command == kvt_pkg::CMD_UPDATE) ||
	                   (req.command == kvt_pkg::CMD_UPSERT) ||
	                   (req.command == kvt_pkg::CMD_ERASE)  ||
	                   (req.command == kvt_pkg::CMD_LOOKUP);

	// cell chain with per-cell hit and control
	for (genvar i = 0; i < kvt_pkg::DEPTH; i++) begin : g_cell
		logic [kvt_pkg::KEY_BITS-1:0]   nb_key;
		logic [kvt_pkg::VALUE_BITS-1:0] nb_value;

		if (i == kvt_pkg::DEPTH - 1) begin : g_last
			assign nb_key   = '0;
			assign nb_value = '0;
		end else begin : g_mid
			assign nb_key   = cell_key[i+1];
			assign nb_value = cell_value[i+1];
		end

		assign hit_d[i] = (count_q > kvt_pkg::CNT_W'(i)) &&
			((req.command == kvt_pkg::CMD_READ) ?
				(32'(req.position) == 32'(i)) : (key_cmd && key_eq[i]));

		assign cell_ctl[i].load_new = apply_go && do_ins && (count_q == kvt_pkg::CNT_W'(i));
		assign cell_ctl[i].load_val = apply_go && do_upd && hit_q[i];
		assign cell_ctl[i].shift    = apply_go && do_erase && after[i];

		kvt_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.cmp_key  (req.req_key),
			.new_key  (key_q),
			.new_value(value_q),
			.nb_key   (nb_key),
			.nb_value (nb_value),
			.key      (cell_key[i]),
			.value    (cell_value[i]),
			.key_eq   (key_eq[i])
		);
	end

	// decide the operation from the registered hit vector
	always_comb begin
		present  = |hit_q;
		ok       = 1'b0;
		do_ins   = 1'b0;
		do_upd   = 1'b0;
		do_erase = 1'b0;
		rd_key   = 1'b0;
		rd_val   = 1'b0;
		case (cmd_q)
			kvt_pkg::CMD_INSERT, kvt_pkg::CMD_UPSERT: begin
				if (present) begin
					ok     = (cmd_q == kvt_pkg::CMD_UPSERT);
					do_upd = (cmd_q == kvt_pkg::CMD_UPSERT);
				end else if (count_q < kvt_pkg::CNT_W'(kvt_pkg::DEPTH)) begin
					ok     = 1'b1;
					do_ins = 1'b1;
				end
			end
			kvt_pkg::CMD_UPDATE: begin
				ok     = present;
				do_upd = present;
			end
			kvt_pkg::CMD_ERASE: begin
				ok       = present;
				do_erase = present;
			end
			kvt_pkg::CMD_LOOKUP: begin
				ok     = present;
				rd_val = present;
			end
			kvt_pkg::CMD_READ: begin
				ok     = present;
				rd_key = present;
				rd_val = present;
			end
			default: ;
		endcase
	end

	// cells at or above the erased one take their neighbour's pair
	always_comb begin
		after = hit_q;
		for (int k = 0; k < kvt_pkg::IDX_W; k++) begin
			after = after | (after << (1 << k));
		end
	end

	// one-hot select of the hit cell's pair
	always_comb begin
		or_key   = '0;
		or_value = '0;
		for (int i = 0; i < kvt_pkg::DEPTH; i++) begin
			or_key   = or_key   | (cell_key[i]   & {kvt_pkg::KEY_BITS{hit_q[i]}});
			or_value = or_value | (cell_value[i] & {kvt_pkg::VALUE_BITS{hit_q[i]}});
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + kvt_pkg::CNT_W'(1);
		end else if (do_erase) begin
			count_d = count_q - kvt_pkg::CNT_W'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (apply_go) begin
						state_q <= ST_IDLE;
						count_q <= count_d;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request and response payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			hit_q   <= hit_d;
			cmd_q   <= req.command;
			key_q   <= req.req_key;
			value_q <= req.req_value;
		end
		if (apply_go) begin
			rsp_q.ok          <= ok;
			rsp_q.found_key   <= rd_key ? or_key : '0;
			rsp_q.found_value <= rd_val ? or_value : '0;
			rsp_q.entries     <= count_d;
			rsp_q.is_empty    <= (count_d == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// keys are unique among live entries, so at most one hit
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> $onehot0(hit_q))
		else $error("more than one cell hit");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kvt_pkg::CNT_W'(kvt_pkg::DEPTH))
		else $error("entry count above depth");

	a_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == ST_APPLY))
		else $error("accepted transaction not applied");

	a_erase_count: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_go && do_erase) |=> (count_q == $past(count_q) - kvt_pkg::CNT_W'(1)))
		else $error("erase did not decrement count");

	a_apply_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go |=> rsp_valid_q)
		else $error("applied transaction produced no response");

endmodule

/* hdl/kvt_cell.sv */
// kvt_cell: one entry of the key/value chain.
// Stores a pair, compares its key, and takes its neighbour's pair on erase.
// Depends on kvt_pkg.
module kvt_cell (
	input  logic                              clk,
	input  kvt_pkg::kvt_cell_ctl_t            ctl,
	input  logic [kvt_pkg::KEY_BITS-1:0]      cmp_key,
	input  logic [kvt_pkg::KEY_BITS-1:0]      new_key,
	input  logic [kvt_pkg::VALUE_BITS-1:0]    new_value,
	input  logic [kvt_pkg::KEY_BITS-1:0]      nb_key,
	input  logic [kvt_pkg::VALUE_BITS-1:0]    nb_value,
	output logic [kvt_pkg::KEY_BITS-1:0]      key,
	output logic [kvt_pkg::VALUE_BITS-1:0]    value,
	output logic                              key_eq
);

	logic [kvt_pkg::KEY_BITS-1:0]   key_q;
	logic [kvt_pkg::VALUE_BITS-1:0] value_q;

	// pair storage; no reset, entries above the count are never read
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end else if (ctl.load_new) begin
			key_q   <= new_key;
			value_q <= new_value;
		end else if (ctl.load_val) begin
			value_q <= new_value;
		end
	end

	assign key    = key_q;
	assign value  = value_q;
	assign key_eq = (key_q == cmp_key);

endmodule
